### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and helpers for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
	localparam int HEAP_BYTES   = 128;
	localparam int HEADER_BYTES = 8;
	localparam int OFF_W        = 7;
	localparam int LINK_W       = 8;
	localparam int NEED_W       = 9;
	localparam int STEP_W       = 8;

	localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(HEAP_BYTES);
	localparam logic [LINK_W-1:0] HDR_LINK   = LINK_W'(HEADER_BYTES);
	localparam logic [LINK_W-1:0] HEAP_SIZE  = LINK_W'(HEAP_BYTES);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FRAG  = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	function automatic logic [LINK_W-1:0] capped_sum(input logic [LINK_W-1:0] a,
		input logic [LINK_W-1:0] b);
		logic [LINK_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > (LINK_W+1)'(HEAP_BYTES)) begin
			s = (LINK_W+1)'(HEAP_BYTES);
		end
		return s[LINK_W-1:0];
	endfunction
endpackage
`default_nettype wire

### rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over an address-ordered free list with coalescing.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries a request: command (0 allocate,
// 1 free), req_size and block_addr. Output channel out_valid/out_ready
// carries one result per request: payload_addr and status.
// A request walks the free list; every step reads the block header from
// the header RAMs with a registered read port. One request is worked on
// at a time; in_ready is high only while the sequencer is idle.
// After reset the whole heap is one free block at offset 0. No clearing
// pass is needed: the header of offset 0 reads its reset value until it is
// first written.
// A result waits in the output register while out_ready is low; the next
// request may be accepted meanwhile, and its result waits until the slot
// frees up.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              command,
	input  wire logic [7:0]        req_size,
	input  wire logic [OFF_W-1:0]  block_addr,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [OFF_W-1:0]  payload_addr,
	output logic      [1:0]        status
);
	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_CHK, S_A_FIT, S_A_SPL, S_A_LNK,
		S_F_TEST, S_F_STEP, S_F_END, S_F_RB, S_F_RC, S_F_RP, S_F_WB, S_F_WP,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [LINK_W-1:0]   head_q, cur_q, prev_q, link_q;
	logic [OFF_W-1:0]    b_q;
	logic [NEED_W-1:0]   need_q;
	logic [STEP_W-1:0]   steps_q;
	logic [LINK_W-1:0]   sz_c_q, lk_c_q, sz_b_q, sz_p_q, nb_q;
	logic [OFF_W-1:0]    res_addr_q;
	logic [1:0]          res_st_q;
	logic                sz_init_q, lk_init_q;
	logic [OFF_W-1:0]    raddr, raddr_q;

	logic                size_we, link_we;
	logic [OFF_W-1:0]    size_waddr, link_waddr;
	logic [LINK_W-1:0]   size_wdata, link_wdata;
	logic [LINK_W-1:0]   size_ram, link_ram, size_rd, link_rd;

	ffha_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_BYTES)) u_size_ram (
		.clk(clk), .we(size_we), .waddr(size_waddr), .wdata(size_wdata),
		.raddr(raddr), .rdata(size_ram)
	);
	ffha_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_BYTES)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(raddr), .rdata(link_ram)
	);

	// offset 0 header keeps its reset value until first written
	assign size_rd = (raddr_q == '0 && sz_init_q) ? HEAP_SIZE : size_ram;
	assign link_rd = (raddr_q == '0 && lk_init_q) ? NIL_LINK : link_ram;

	logic [NEED_W-1:0]  rest;
	logic [NEED_W:0]    split_end;
	logic               split_ok, fwd_merge, back_merge;
	logic [LINK_W:0]    b_end, p_end;
	logic [OFF_W-1:0]   nb_off;

	assign rest      = {1'b0, sz_c_q} - need_q;
	assign split_end = {2'b0, cur_q[OFF_W-1:0]} + {1'b0, need_q};
	assign split_ok  = rest > NEED_W'(HEADER_BYTES) && split_end < (NEED_W+1)'(HEAP_BYTES);
	assign nb_off    = split_end[OFF_W-1:0];
	assign b_end     = {2'b0, b_q} + {1'b0, sz_b_q};
	assign p_end     = {1'b0, prev_q} + {1'b0, sz_p_q};
	assign fwd_merge = cur_q < NIL_LINK && b_end == {1'b0, cur_q};
	assign back_merge = p_end == (LINK_W+1)'(b_q);

	always_comb begin
		raddr      = cur_q[OFF_W-1:0];
		size_we    = 1'b0;
		link_we    = 1'b0;
		size_waddr = cur_q[OFF_W-1:0];
		link_waddr = cur_q[OFF_W-1:0];
		size_wdata = '0;
		link_wdata = '0;
		case (state_q)
			S_F_END: raddr = b_q;
			S_F_RC:  raddr = prev_q[OFF_W-1:0];
			S_A_FIT: begin
				if (split_ok) begin
					size_we    = 1'b1;
					link_we    = 1'b1;
					size_waddr = nb_off;
					link_waddr = nb_off;
					size_wdata = rest[LINK_W-1:0];
					link_wdata = lk_c_q;
				end
			end
			S_A_SPL: begin
				size_we    = 1'b1;
				size_wdata = need_q[LINK_W-1:0];
			end
			S_A_LNK: begin
				link_we    = prev_q < NIL_LINK;
				link_waddr = prev_q[OFF_W-1:0];
				link_wdata = link_q;
			end
			S_F_WB: begin
				size_we    = 1'b1;
				link_we    = 1'b1;
				size_waddr = b_q;
				link_waddr = b_q;
				size_wdata = fwd_merge ? capped_sum(sz_b_q, sz_c_q) : sz_b_q;
				link_wdata = fwd_merge ? lk_c_q : cur_q;
			end
			S_F_WP: begin
				size_we    = prev_q < NIL_LINK && back_merge;
				link_we    = prev_q < NIL_LINK;
				size_waddr = prev_q[OFF_W-1:0];
				link_waddr = prev_q[OFF_W-1:0];
				size_wdata = capped_sum(sz_p_q, sz_b_q);
				link_wdata = back_merge ? nb_q : LINK_W'(b_q);
			end
			default: begin
				raddr = cur_q[OFF_W-1:0];
			end
		endcase
	end

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			sz_init_q <= 1'b1;
			lk_init_q <= 1'b1;
			out_valid <= 1'b0;
			raddr_q   <= '0;
		end else begin
			raddr_q <= raddr;
			if (size_we && size_waddr == '0) begin
				sz_init_q <= 1'b0;
			end
			if (link_we && link_waddr == '0) begin
				lk_init_q <= 1'b0;
			end
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						need_q     <= {1'b0, req_size} + NEED_W'(HEADER_BYTES);
						b_q        <= block_addr - OFF_W'(HEADER_BYTES);
						cur_q      <= head_q;
						prev_q     <= NIL_LINK;
						steps_q    <= '0;
						res_addr_q <= '0;
						res_st_q   <= ST_OK;
						if (command == CMD_ALLOC) begin
							if (head_q >= NIL_LINK) begin
								res_st_q <= ST_EMPTY;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_A_RD;
							end
						end else if (block_addr < OFF_W'(HEADER_BYTES)) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_F_TEST;
						end
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if ({1'b0, size_rd} >= need_q) begin
						sz_c_q  <= size_rd;
						lk_c_q  <= link_rd;
						state_q <= S_A_FIT;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= link_rd;
						steps_q <= steps_q + 1'b1;
						if (steps_q == STEP_W'(HEAP_BYTES - 1) || link_rd >= NIL_LINK) begin
							res_st_q <= ST_FRAG;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_A_RD;
						end
					end
				end
				S_A_FIT: begin
					if (split_ok) begin
						link_q  <= LINK_W'(nb_off);
						state_q <= S_A_SPL;
					end else begin
						link_q  <= lk_c_q;
						state_q <= S_A_LNK;
					end
				end
				S_A_SPL: state_q <= S_A_LNK;
				S_A_LNK: begin
					if (prev_q >= NIL_LINK) begin
						head_q <= link_q;
					end
					res_addr_q <= cur_q[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
					state_q    <= S_OUT;
				end
				S_F_TEST: begin
					if (steps_q < STEP_W'(HEAP_BYTES) && cur_q < NIL_LINK
						&& cur_q < LINK_W'(b_q)) begin
						state_q <= S_F_STEP;
					end else begin
						state_q <= S_F_END;
					end
				end
				S_F_STEP: begin
					prev_q  <= cur_q;
					cur_q   <= link_rd;
					steps_q <= steps_q + 1'b1;
					state_q <= S_F_TEST;
				end
				S_F_END: begin
					if (cur_q == LINK_W'(b_q)) begin
						state_q <= S_OUT;
					end else begin
						if (cur_q >= NIL_LINK) begin
							cur_q <= NIL_LINK;
						end
						state_q <= S_F_RB;
					end
				end
				S_F_RB: begin
					sz_b_q  <= size_rd;
					state_q <= S_F_RC;
				end
				S_F_RC: begin
					sz_c_q  <= size_rd;
					lk_c_q  <= link_rd;
					state_q <= S_F_RP;
				end
				S_F_RP: begin
					sz_p_q  <= size_rd;
					state_q <= S_F_WB;
				end
				S_F_WB: begin
					sz_b_q  <= size_wdata;
					nb_q    <= link_wdata;
					state_q <= S_F_WP;
				end
				S_F_WP: begin
					if (prev_q >= NIL_LINK) begin
						head_q <= LINK_W'(b_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						payload_addr <= res_addr_q;
						status       <= res_st_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_checker import ffha_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [OFF_W-1:0] payload_addr,
	input wire logic [1:0]       status
);
	// an accepted request makes the block busy, so in_ready is low in the cycle after it
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after request");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_addr == '0)
		else $error("failed result with nonzero address");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FRAG))
		else $error("bad status code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_addr) && $stable(status))
		else $error("result changed while stalled");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.payload_addr(payload_addr), .status(status)
);
`default_nettype wire

### verif/heap_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_alloc_checker
// Watches both channels of the first-fit heap allocator, keeps its own copy
// of the free list, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module heap_alloc_checker import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              command,
	input  logic [7:0]        req_size,
	input  logic [OFF_W-1:0]  block_addr,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [OFF_W-1:0]  payload_addr,
	input  logic [1:0]        status,
	output int                fail_count,
	output int                pending
);
	typedef struct packed {
		logic [OFF_W-1:0] addr;
		logic [1:0]       st;
	} alloc_result_t;

	alloc_result_t result_q[$];
	int blk_size[HEAP_BYTES];
	int blk_next[HEAP_BYTES];
	int head;

	initial begin
		fail_count = 0;
		for (int i = 0; i < HEAP_BYTES; i++) begin
			blk_size[i] = 0;
			blk_next[i] = 0;
		end
		blk_size[0] = HEAP_BYTES;
		blk_next[0] = HEAP_BYTES;
		head = 0;
	end

	assign pending = result_q.size();

	function automatic int merged(int a, int b);
		return (a + b > HEAP_BYTES) ? HEAP_BYTES : a + b;
	endfunction

	function automatic void relink(int prev, int target);
		if (prev < HEAP_BYTES) begin
			blk_next[prev] = target;
		end else begin
			head = target;
		end
	endfunction

	function automatic alloc_result_t allocate(int req);
		alloc_result_t r;
		int need, prev, cur, link, rest;
		bit found;
		need = req + HEADER_BYTES;
		prev = HEAP_BYTES;
		cur = head;
		found = 0;
		r.addr = '0;
		if (head >= HEAP_BYTES) begin
			r.st = ST_EMPTY;
			return r;
		end
		for (int n = 0; n < HEAP_BYTES && cur < HEAP_BYTES; n++) begin
			if (blk_size[cur] >= need) begin
				found = 1;
				break;
			end
			prev = cur;
			cur = blk_next[cur];
		end
		if (!found) begin
			r.st = ST_FRAG;
			return r;
		end
		rest = blk_size[cur] - need;
		link = blk_next[cur];
		if (rest > HEADER_BYTES && cur + need < HEAP_BYTES) begin
			blk_size[cur + need] = rest;
			blk_next[cur + need] = link;
			blk_size[cur] = need;
			link = cur + need;
		end
		relink(prev, link);
		r.addr = OFF_W'(cur + HEADER_BYTES);
		r.st = ST_OK;
		return r;
	endfunction

	function automatic void release_block(int addr);
		int b, prev, cur;
		if (addr < HEADER_BYTES) begin
			return;
		end
		b = addr - HEADER_BYTES;
		prev = HEAP_BYTES;
		cur = head;
		for (int n = 0; n < HEAP_BYTES && cur < HEAP_BYTES && cur < b; n++) begin
			prev = cur;
			cur = blk_next[cur];
		end
		if (cur == b) begin
			return;
		end
		if (cur >= HEAP_BYTES) begin
			cur = HEAP_BYTES;
		end
		blk_next[b] = cur;
		relink(prev, b);
		if (cur < HEAP_BYTES && b + blk_size[b] == cur) begin
			blk_size[b] = merged(blk_size[b], blk_size[cur]);
			blk_next[b] = blk_next[cur];
		end
		if (prev < HEAP_BYTES && prev + blk_size[prev] == b) begin
			blk_size[prev] = merged(blk_size[prev], blk_size[b]);
			blk_next[prev] = blk_next[b];
		end
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		alloc_result_t r, e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (command == CMD_ALLOC) begin
					r = allocate(int'(req_size));
				end else begin
					release_block(int'(block_addr));
					r.addr = '0;
					r.st = ST_OK;
				end
				result_q.push_back(r);
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report("unexpected result, status", status, -1);
				end else begin
					e = result_q.pop_front();
					if (payload_addr !== e.addr) begin
						report("payload_addr", payload_addr, e.addr);
					end
					if (status !== e.st) begin
						report("status", status, e.st);
					end
				end
			end
		end
	end
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the first-fit heap allocator: directed allocate and free
// requests, then random traffic with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import ffha_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             command = CMD_ALLOC;
	logic [7:0]       req_size = '0;
	logic [OFF_W-1:0] block_addr = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [OFF_W-1:0] payload_addr;
	logic [1:0]       status;
	int               fail_count;
	int               pending;
	int               send_idle = 0;
	int               recv_idle = 0;
	int               hold_cycles = 0;
	int               quiet_cycles = 0;
	int               live_addr[$];

	always #6 clk = ~clk;

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .req_size(req_size), .block_addr(block_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_addr(payload_addr), .status(status)
	);

	heap_alloc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .req_size(req_size), .block_addr(block_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_addr(payload_addr), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver stalls and long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// allocated payload offsets become freeable once returned
	always @(posedge clk) begin
		if (out_valid && out_ready && payload_addr != 0) begin
			live_addr.push_back(int'(payload_addr));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= 5000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(logic cmd, int size, int addr);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		command <= cmd;
		req_size <= 8'(size);
		block_addr <= OFF_W'(addr);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic free_live(int idx);
		int a;
		a = live_addr[idx];
		live_addr.delete(idx);
		send(CMD_FREE, $urandom_range(255), a);
	endtask

	initial begin
		int a;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_ALLOC, 0, 0);
		send(CMD_ALLOC, 128, 0);
		settle();
		a = live_addr.pop_front();
		send(CMD_FREE, 0, a);
		send(CMD_FREE, 0, a);
		send(CMD_FREE, 0, 3);
		send(CMD_FREE, 0, 0);
		send(CMD_FREE, 0, 7);
		send(CMD_ALLOC, 120, 0);
		send(CMD_ALLOC, 1, 0);
		send(CMD_ALLOC, 255, 0);
		settle();
		free_live(0);
		send(CMD_ALLOC, 111, 0);
		send(CMD_ALLOC, 112, 0);
		send(CMD_ALLOC, 0, 0);
		settle();
		while (live_addr.size() > 0) free_live(0);
		send(CMD_ALLOC, 112, 0);
		send(CMD_ALLOC, 16, 0);
		send(CMD_ALLOC, 24, 0);
		send(CMD_ALLOC, 8, 0);
		send(CMD_ALLOC, 40, 0);
		settle();
		while (live_addr.size() > 0) free_live(live_addr.size() - 1);
		settle();

		for (int i = 0; i < 800; i++) begin
			if (i == 0) begin
				send_idle = 21;
				recv_idle = 77;
				hold_cycles = 300;
			end else if (i == 267) begin
				send_idle = 77;
				recv_idle = 21;
			end else if (i == 534) begin
				send_idle = 0;
				recv_idle = 0;
			end
			a = $urandom_range(99);
			if (a < 3) begin
				send(CMD_FREE, $urandom_range(255), $urandom_range(HEADER_BYTES - 1));
			end else if (live_addr.size() == 0 || a < 55) begin
				if ($urandom_range(19) == 0) begin
					send(CMD_ALLOC, $urandom_range(90, 255), $urandom_range(127));
				end else begin
					send(CMD_ALLOC, $urandom_range(24), $urandom_range(127));
				end
			end else begin
				free_live($urandom_range(live_addr.size() - 1));
			end
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

### sim.f
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
verif/heap_alloc_checker.sv
verif/tb_top.sv
